@@ sv/crr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crr_pkg
// Shared codes, field widths and types of the command range router.
// ----------------------------------------------------------------------------
package crr_pkg;

   localparam int MAX_SLOTS_DEFAULT = 16;

   localparam int REQ_TYPE_W  = 2;
   localparam int CODE_W      = 8;
   localparam int STATUS_W    = 2;
   localparam int SLOT_IDX_W  = 4;
   localparam int ENTRY_CNT_W = 5;

   // request kinds
   localparam logic [REQ_TYPE_W-1:0] REQ_REGISTER = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_LOOKUP   = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR    = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL        = 2'd1;
   localparam logic [STATUS_W-1:0] ST_CONFLICT    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 2'd3;

   // one table entry, start in the upper byte
   typedef struct packed {
      logic [CODE_W-1:0] range_start;
      logic [CODE_W-1:0] range_end;
   } entry_type;

   // finished result handed from the sequencer to the output register
   typedef struct packed {
      logic [ENTRY_CNT_W-1:0] entry_count;
      logic [SLOT_IDX_W-1:0]  slot_index;
      logic [STATUS_W-1:0]    status;
   } result_type;

endpackage
`default_nettype wire

@@ sv/crr_table_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crr_table_mem
// Range table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module crr_table_mem #(
   parameter int DEPTH  = crr_pkg::MAX_SLOTS_DEFAULT,
   parameter int ADDR_W = 4
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [ADDR_W-1:0]   wr_addr,
   input  wire crr_pkg::entry_type  wr_data,
   input  wire logic [ADDR_W-1:0]   rd_addr,
   output crr_pkg::entry_type       rd_data
);

   crr_pkg::entry_type entry_mem [DEPTH];
   crr_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= entry_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ sv/crr_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crr_ctrl
// Request sequencer: walks the stored slots one per cycle, decides the
// outcome and commits table updates when the result is handed off.
// ----------------------------------------------------------------------------
module crr_ctrl #(
   parameter int MAX_SLOTS = crr_pkg::MAX_SLOTS_DEFAULT,
   parameter int ADDR_W    = 4,
   parameter int CNT_W     = 5
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [crr_pkg::REQ_TYPE_W-1:0] req_type,
   input  wire logic [crr_pkg::CODE_W-1:0]     range_start,
   input  wire logic [crr_pkg::CODE_W-1:0]     range_end,
   input  wire logic [crr_pkg::CODE_W-1:0]     lookup_code,
   output logic                                res_valid,
   input  wire logic                           res_ready,
   output crr_pkg::result_type                 res_data,
   output logic                                wr_en,
   output logic [ADDR_W-1:0]                   wr_addr,
   output crr_pkg::entry_type                  wr_data,
   output logic [ADDR_W-1:0]                   rd_addr,
   input  wire crr_pkg::entry_type             rd_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0]                         state_ff, state_in;
   logic [crr_pkg::REQ_TYPE_W-1:0]     op_ff, op_in;
   logic [crr_pkg::CODE_W-1:0]         rs_ff, rs_in;
   logic [crr_pkg::CODE_W-1:0]         re_ff, re_in;
   logic [crr_pkg::CODE_W-1:0]         code_ff, code_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic [ADDR_W-1:0]                  idx_ff, idx_in;
   logic [crr_pkg::STATUS_W-1:0]       status_ff, status_in;
   logic [ADDR_W-1:0]                  slot_ff, slot_in;

   logic is_full;
   logic is_empty;
   logic is_last;
   logic overlap;
   logic contains;

   assign is_full  = (count_ff >= CNT_W'(MAX_SLOTS));
   assign is_empty = (count_ff == '0);
   assign is_last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign overlap  = !((re_ff < rd_data.range_start) || (rs_ff > rd_data.range_end));
   assign contains = (code_ff >= rd_data.range_start) && (code_ff <= rd_data.range_end);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      rs_in     = rs_ff;
      re_in     = re_ff;
      code_in   = code_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      slot_in   = slot_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      wr_en     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req_type;
               rs_in     = range_start;
               re_in     = range_end;
               code_in   = lookup_code;
               idx_in    = '0;
               slot_in   = '0;
               state_in  = S_RESP;
               status_in = crr_pkg::ST_UNSUPPORTED;
               unique case (req_type)
                  crr_pkg::REQ_REGISTER: begin
                     if (is_full) begin
                        status_in = crr_pkg::ST_FULL;
                     end else if (is_empty) begin
                        status_in = crr_pkg::ST_OK;
                        slot_in   = count_ff[ADDR_W-1:0];
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  crr_pkg::REQ_LOOKUP: begin
                     if (!is_empty) begin
                        state_in = S_SCAN;
                     end
                  end
                  crr_pkg::REQ_CLEAR: begin
                     status_in = crr_pkg::ST_OK;
                  end
                  default: begin
                     status_in = crr_pkg::ST_UNSUPPORTED;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // read data belongs to slot idx_ff
            if (op_ff == crr_pkg::REQ_REGISTER) begin
               if (overlap) begin
                  status_in = crr_pkg::ST_CONFLICT;
                  state_in  = S_RESP;
               end else if (is_last) begin
                  status_in = crr_pkg::ST_OK;
                  slot_in   = count_ff[ADDR_W-1:0];
                  state_in  = S_RESP;
               end else begin
                  idx_in = idx_ff + ADDR_W'(1);
               end
            end else begin
               if (contains) begin
                  status_in = crr_pkg::ST_OK;
                  slot_in   = idx_ff;
                  state_in  = S_RESP;
               end else if (is_last) begin
                  status_in = crr_pkg::ST_UNSUPPORTED;
                  state_in  = S_RESP;
               end else begin
                  idx_in = idx_ff + ADDR_W'(1);
               end
            end
         end
         S_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               // commit the table update with the hand-off
               if ((op_ff == crr_pkg::REQ_REGISTER) && (status_ff == crr_pkg::ST_OK)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else if (op_ff == crr_pkg::REQ_CLEAR) begin
                  count_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      logic [CNT_W-1:0] after_count;
      after_count = count_ff;
      if ((op_ff == crr_pkg::REQ_REGISTER) && (status_ff == crr_pkg::ST_OK)) begin
         after_count = count_ff + CNT_W'(1);
      end else if (op_ff == crr_pkg::REQ_CLEAR) begin
         after_count = '0;
      end
      res_data.status      = status_ff;
      res_data.slot_index  = crr_pkg::SLOT_IDX_W'(slot_ff);
      res_data.entry_count = crr_pkg::ENTRY_CNT_W'(after_count);
   end

   assign wr_addr = count_ff[ADDR_W-1:0];
   assign wr_data = {rs_ff, re_ff};
   assign rd_addr = idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      rs_ff     <= rs_in;
      re_ff     <= re_in;
      code_ff   <= code_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
   end

endmodule
`default_nettype wire

@@ sv/command_range_router.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// command_range_router
// Table of command-code ranges with register, lookup and clear requests.
// ----------------------------------------------------------------------------
// A request is taken in the idle state. Register requests on a table that is
// not full and lookup requests then walk the stored slots through the table
// memory's single read port, one slot per cycle, stopping at the first
// overlap or match; the response state then hands the result to the output
// register once it is free. Clear, full-table and unused request kinds go
// straight to the response state. The output register lets the next request
// enter while a response waits on rsp_tready. The table needs no clearing
// pass after reset: only slots below the entry count are ever read.
// ----------------------------------------------------------------------------
module command_range_router #(
   parameter int MAX_SLOTS = crr_pkg::MAX_SLOTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // range_start[7:0], range_end[15:8], lookup_code[23:16]
   input  wire logic [1:0]  req_tuser,   // req_type[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // status[1:0], slot_index[5:2], entry_count[10:6]
);

   localparam int ADDR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

   logic                  res_valid;
   logic                  res_ready;
   crr_pkg::result_type   res_data;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   crr_pkg::entry_type    wr_data;
   logic [ADDR_W-1:0]     rd_addr;
   crr_pkg::entry_type    rd_data;

   logic                  rsp_valid_ff, rsp_valid_in;
   crr_pkg::result_type   rsp_data_ff;

   crr_ctrl #(
      .MAX_SLOTS (MAX_SLOTS),
      .ADDR_W    (ADDR_W),
      .CNT_W     (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_type    (req_tuser),
      .range_start (req_tdata[7:0]),
      .range_end   (req_tdata[15:8]),
      .lookup_code (req_tdata[23:16]),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_data    (res_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   crr_table_mem #(
      .DEPTH  (MAX_SLOTS),
      .ADDR_W (ADDR_W)
   ) u_table_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // load a new response once the held one is gone or leaves this cycle
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

endmodule
`default_nettype wire
